// ===== rtl/nhp_pkg.sv =====
// ----------------------------------------------------------------------------
// nhp_pkg: shared definitions for the nonlinear Hamming parity encoder
// Field size, code layout constants and the data-bit to code-position map.
// ----------------------------------------------------------------------------
`default_nettype none

package nhp_pkg;

   // Field and code layout
   localparam int FIELD_BITS     = 6;
   localparam int DATA_BITS      = 32;
   localparam int CODE_POSITIONS = 38;
   localparam int POS_BITS       = 6;
   localparam int POLY_RESET     = 67;

   typedef logic [POS_BITS-1:0] pos_type;
   typedef pos_type [DATA_BITS-1:0] pos_map_type;

   // Return the 1-based code position of data bit idx: data fills the
   // positions that are not powers of two, in ascending order.
   function automatic pos_type data_pos(input int idx);
      int cnt;
      pos_type res;
      cnt = 0;
      res = '0;
      for (int p = 1; p <= CODE_POSITIONS; p++) begin
         if ((p & (p - 1)) != 0) begin
            if (cnt == idx) begin
               res = POS_BITS'(p);
            end
            cnt++;
         end
      end
      return res;
   endfunction

   // Build the full position table once at elaboration
   function automatic pos_map_type build_pos_map();
      pos_map_type map;
      for (int i = 0; i < DATA_BITS; i++) begin
         map[i] = data_pos(i);
      end
      return map;
   endfunction

   localparam pos_map_type DATA_POS_MAP = build_pos_map();

endpackage

`default_nettype wire

// ===== rtl/nhp_gf_mult.sv =====
// ----------------------------------------------------------------------------
// nhp_gf_mult: registered GF(2^m) multiply stage
// Carry-less product of two field elements, reduced by the field polynomial,
// held in an output register with its own valid bit and stall handshake.
// A side value travels alongside the product unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module nhp_gf_mult #(
   parameter int FIELD_BITS = nhp_pkg::FIELD_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [FIELD_BITS-1:0] poly,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [FIELD_BITS-1:0] in_a,
   input  wire logic [FIELD_BITS-1:0] in_b,
   input  wire logic [FIELD_BITS-1:0] in_side,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [FIELD_BITS-1:0]      out_prod,
   output logic [FIELD_BITS-1:0]      out_side
);
   import nhp_pkg::*;

   localparam int PROD_BITS = 2 * FIELD_BITS - 1;

   logic [PROD_BITS-1:0]  poly_full;
   logic [PROD_BITS-1:0]  prod;
   logic [FIELD_BITS-1:0] prod_in;
   logic                  valid_ff;
   logic                  valid_in;
   logic [FIELD_BITS-1:0] prod_ff;
   logic [FIELD_BITS-1:0] side_ff;

   // Multiply carry-less, then fold the high terms back from the top down
   always_comb begin
      poly_full = PROD_BITS'({1'b1, poly});
      prod = '0;
      for (int i = 0; i < FIELD_BITS; i++) begin
         if (in_b[i]) begin
            prod = prod ^ (PROD_BITS'(in_a) << i);
         end
      end
      for (int k = PROD_BITS - 1; k >= FIELD_BITS; k--) begin
         if (prod[k]) begin
            prod = prod ^ (poly_full << (k - FIELD_BITS));
         end
      end
      prod_in = prod[FIELD_BITS-1:0];
   end

   // Take a new transaction when the register is empty or draining
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload only on an accepted transaction
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_ff <= prod_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_prod  = prod_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

// ===== rtl/nonlinear_hamming_parity_top.sv =====
// ----------------------------------------------------------------------------
// nonlinear_hamming_parity_top: robust nonlinear Hamming parity encoder
// Linear Hamming check bits of a 32-bit word and their cube in GF(2^6).
// ----------------------------------------------------------------------------
// The encoder accepts one 32-bit word per clock while not stalled and
// returns the six linear Hamming check bits (data placed in the non-power-
// of-two positions 3..38) together with their cube modulo the programmed
// field polynomial. The three register stages are the check-bit XOR tree,
// the squaring multiplier and the cubing multiplier; each stage holds its
// own valid bit, so a stalled output fills the pipeline before the input
// stalls and sustained throughput is one transaction per cycle. Bit 6 of the
// polynomial register is ignored: the x^6 term is always taken as present.
// Write the polynomial only while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module nonlinear_hamming_parity_top #(
   parameter int FIELD_BITS = nhp_pkg::FIELD_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration
   input  wire logic                                csr_we,
   input  wire logic [FIELD_BITS:0]                 csr_wdata,   // reduction_poly
   // input stream
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [nhp_pkg::DATA_BITS-1:0]       req_tdata,   // data_word
   // result stream
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // linear_parity, robust_parity, zero fill
   output logic [((2*FIELD_BITS+7)/8)*8-1:0]        rsp_tdata
);
   import nhp_pkg::*;

   localparam int RSP_BITS = ((2 * FIELD_BITS + 7) / 8) * 8;

   logic [FIELD_BITS-1:0] poly_ff;
   logic [FIELD_BITS-1:0] lin_in;
   logic [FIELD_BITS-1:0] lin_ff;
   logic                  v1_ff;
   logic                  v1_in;
   logic                  s1_ready;
   logic                  sq_in_ready;
   logic                  sq_valid;
   logic                  cube_in_ready;
   logic [FIELD_BITS-1:0] sq_prod;
   logic [FIELD_BITS-1:0] sq_lin;
   logic [FIELD_BITS-1:0] cube_prod;
   logic [FIELD_BITS-1:0] cube_lin;

   // Hold the field polynomial low terms
   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= FIELD_BITS'(POLY_RESET);
      end else if (csr_we) begin
         poly_ff <= csr_wdata[FIELD_BITS-1:0];
      end
   end

   // Stage 1: XOR the code positions of all set data bits
   always_comb begin
      lin_in = '0;
      for (int i = 0; i < DATA_BITS; i++) begin
         if (req_tdata[i]) begin
            lin_in = lin_in ^ DATA_POS_MAP[i][FIELD_BITS-1:0];
         end
      end
   end

   assign s1_ready   = !v1_ff || sq_in_ready;
   assign req_tready = s1_ready;
   assign v1_in      = s1_ready ? req_tvalid : v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && s1_ready) begin
         lin_ff <= lin_in;
      end
   end

   // Stage 2: square the linear parity
   nhp_gf_mult #(.FIELD_BITS(FIELD_BITS)) u_square (
      .clock     (clock),
      .reset     (reset),
      .poly      (poly_ff),
      .in_valid  (v1_ff),
      .in_ready  (sq_in_ready),
      .in_a      (lin_ff),
      .in_b      (lin_ff),
      .in_side   (lin_ff),
      .out_valid (sq_valid),
      .out_ready (cube_in_ready),
      .out_prod  (sq_prod),
      .out_side  (sq_lin)
   );

   // Stage 3: multiply by the square to form the cube; this is the output register
   nhp_gf_mult #(.FIELD_BITS(FIELD_BITS)) u_cube (
      .clock     (clock),
      .reset     (reset),
      .poly      (poly_ff),
      .in_valid  (sq_valid),
      .in_ready  (cube_in_ready),
      .in_a      (sq_lin),
      .in_b      (sq_prod),
      .in_side   (sq_lin),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_prod  (cube_prod),
      .out_side  (cube_lin)
   );

   // Pack the result fields, linear parity lowest
   assign rsp_tdata = RSP_BITS'({cube_prod, cube_lin});

endmodule

`default_nettype wire

// ===== rtl/nhp_checker.sv =====
// ----------------------------------------------------------------------------
// nhp_checker: port-level checks for the nonlinear Hamming parity encoder
// Watches the top level's result stream and flags handshake and result slips.
// ----------------------------------------------------------------------------
`default_nettype none

module nhp_checker #(
   parameter int FIELD_BITS = nhp_pkg::FIELD_BITS
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [((2*FIELD_BITS+7)/8)*8-1:0]   rsp_tdata
);
   import nhp_pkg::*;

   localparam int RSP_BITS = ((2 * FIELD_BITS + 7) / 8) * 8;

   logic [FIELD_BITS-1:0] lin;
   logic [FIELD_BITS-1:0] rob;

   assign lin = rsp_tdata[FIELD_BITS-1:0];
   assign rob = rsp_tdata[2*FIELD_BITS-1:FIELD_BITS];

   // A stalled result holds its valid
   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result valid dropped while stalled");

   // A stalled result holds its data
   a_rsp_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result data changed while stalled");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // The cube of zero is zero, whatever the polynomial
   a_zero_cube: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (lin == '0) |-> (rob == '0))
      else $error("nonzero robust parity for zero linear parity");

   // Fill bits above the result fields stay zero
   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >> (2 * FIELD_BITS)) == RSP_BITS'(0))
      else $error("nonzero fill bits in result");

endmodule

bind nonlinear_hamming_parity_top nhp_checker #(.FIELD_BITS(FIELD_BITS)) u_nhp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
